FILE: hdl/agdm_pkg.sv
`timescale 1ns / 1ps
package agdm_pkg;

    localparam int SAMPLE_BITS = 12;
    localparam logic [SAMPLE_BITS-1:0] SMAX = {SAMPLE_BITS{1'b1}};

    localparam int WEIGHT_BITS = 16;
    localparam int FRAC_BITS   = 16;
    localparam int AVG_W       = SAMPLE_BITS + FRAC_BITS;

    // 255^2 * 4, compared against (2k-1)^2
    localparam int GAMMA_BITS = 18;
    localparam logic [GAMMA_BITS-1:0] GAMMA_SCALE = GAMMA_BITS'(260100);

    // quotient bits of the gamma divide, also the square root radicand width
    localparam int QB         = 18;
    localparam int ROOT_W     = QB / 2;
    localparam int DUTY_W     = 8;
    localparam int CEIL_MUL_W = 9;
    localparam logic [CEIL_MUL_W-1:0] CEIL_MUL = CEIL_MUL_W'(510);

    // ceiling quotient (knob*510 + SMAX) / (2*SMAX) through a reciprocal multiply,
    // the shift covers every numerator below 2^CEIL_NUM_W
    localparam int     CEIL_NUM_W   = SAMPLE_BITS + CEIL_MUL_W;
    localparam longint CEIL_DIV     = 2 * longint'(SMAX);
    localparam int     CEIL_SHIFT   = CEIL_NUM_W + $clog2(CEIL_DIV);
    localparam longint CEIL_ONE     = longint'(1) << CEIL_SHIFT;
    localparam int     CEIL_RECIP_W = CEIL_NUM_W + 1;
    localparam logic [CEIL_RECIP_W-1:0] CEIL_RECIP =
        CEIL_RECIP_W'((CEIL_ONE + CEIL_DIV - 1) / CEIL_DIV);
    localparam int     CEIL_PROD_W  = CEIL_NUM_W + CEIL_RECIP_W;

    // width of the shared compare-subtract unit
    localparam int UW = (SAMPLE_BITS + 2 > 12) ? SAMPLE_BITS + 2 : 12;

    localparam int CNT_W = $clog2(QB);

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERT        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EMA_WEIGHT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SPAN      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CEILING_FLOOR = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RANGE,
        S_NORM,
        S_NUM,
        S_SCALE,
        S_DIV,
        S_ROOT,
        S_CEIL,
        S_FIN
    } t_state;

    typedef struct packed {
        logic                   start;
        logic [SAMPLE_BITS-1:0] sample;
    } t_avg_cmd;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] level;
        logic [SAMPLE_BITS-1:0] low;
        logic [SAMPLE_BITS-1:0] high;
    } t_light_stat;

endpackage

FILE: hdl/agdm_sub_unit.sv
`timescale 1ns / 1ps
module agdm_sub_unit (
    input  logic [agdm_pkg::UW-1:0] i_a,
    input  logic [agdm_pkg::UW-1:0] i_b,
    output logic [agdm_pkg::UW-1:0] o_diff,
    output logic                    o_ge
);

    logic [agdm_pkg::UW:0] w_sub;

    // borrow out of the extended subtract gives the compare
    assign w_sub  = {1'b0, i_a} - {1'b0, i_b};
    assign o_diff = w_sub[agdm_pkg::UW-1:0];
    assign o_ge   = ~w_sub[agdm_pkg::UW];

endmodule

FILE: hdl/agdm_light_avg.sv
`timescale 1ns / 1ps
module agdm_light_avg (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  agdm_pkg::t_avg_cmd                 i_cmd,
    input  logic [agdm_pkg::WEIGHT_BITS-1:0]   i_weight,
    output agdm_pkg::t_light_stat              o_stat
);

    localparam int AW     = agdm_pkg::AVG_W;
    localparam int SB     = agdm_pkg::SAMPLE_BITS;
    localparam int FB     = agdm_pkg::FRAC_BITS;
    localparam int PROD_W = agdm_pkg::WEIGHT_BITS + 1 + AW + 1;

    logic                   r_started;
    logic                   r_v1;
    logic                   r_v2;
    logic [AW-1:0]          r_avg;
    logic [AW-1:0]          r_base;
    logic signed [PROD_W-1:0] r_prod;
    logic [SB-1:0]          r_low;
    logic [SB-1:0]          r_high;

    logic [AW-1:0]            w_base;
    logic signed [AW:0]       w_delta;
    logic signed [PROD_W-1:0] w_prod;
    logic signed [PROD_W-1:0] w_rnd_sum;
    logic signed [PROD_W-1:0] w_rnd;
    logic [AW-1:0]            n_avg;
    logic [SB-1:0]            w_level;

    // first sample after reset seeds the average
    assign w_base  = r_started ? r_avg : {i_cmd.sample, {FB{1'b0}}};
    assign w_delta = $signed({1'b0, i_cmd.sample, {FB{1'b0}}}) - $signed({1'b0, w_base});
    assign w_prod  = PROD_W'($signed({1'b0, i_weight})) * PROD_W'(w_delta);

    // avg + round(w*(x-avg)/2^16), same as the weighted sum form
    assign w_rnd_sum = r_prod + $signed(PROD_W'(1 << (FB - 1)));
    assign w_rnd     = w_rnd_sum >>> FB;
    assign n_avg     = r_base + w_rnd[AW-1:0];
    assign w_level   = r_avg[AW-1:FB];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started <= 1'b0;
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            r_avg     <= '0;
            r_low     <= agdm_pkg::SMAX;
            r_high    <= '0;
        end else begin
            r_v1 <= i_cmd.start;
            r_v2 <= r_v1;
            if (i_cmd.start) begin
                r_started <= 1'b1;
            end
            if (r_v1) begin
                r_avg <= n_avg;
            end
            if (r_v2) begin
                if (w_level < r_low) begin
                    r_low <= w_level;
                end
                if (w_level > r_high) begin
                    r_high <= w_level;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_base <= w_base;
            r_prod <= w_prod;
        end
    end

    assign o_stat.level = w_level;
    assign o_stat.low   = r_low;
    assign o_stat.high  = r_high;

endmodule

FILE: hdl/autorange_gamma_duty_mapper_unit.sv
`timescale 1ns / 1ps
// the shared compare-subtract unit carries out 18 gamma divide steps, then 9
// square root steps; a new transaction is taken only in the idle state, after
// the previous result has gone into the output register
// reset (i_rst_n low, synchronous): settings back to defaults, knob and light
// ranges emptied, average reseeded by the next sample, no result pending
module autorange_gamma_duty_mapper_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [agdm_pkg::SAMPLE_BITS-1:0]    i_light_sample,
    input  logic [agdm_pkg::SAMPLE_BITS-1:0]    i_knob_sample,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [agdm_pkg::DUTY_W-1:0]         o_duty,
    output logic [agdm_pkg::SAMPLE_BITS-1:0]    o_light_level,
    output logic [agdm_pkg::SAMPLE_BITS-1:0]    o_light_low,
    output logic [agdm_pkg::SAMPLE_BITS-1:0]    o_light_high,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [agdm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [agdm_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int SB = agdm_pkg::SAMPLE_BITS;
    localparam int UW = agdm_pkg::UW;
    localparam int QB = agdm_pkg::QB;
    localparam int RW = agdm_pkg::ROOT_W;
    localparam int DW = agdm_pkg::DUTY_W;
    localparam int CW = agdm_pkg::CNT_W;
    localparam int CM = agdm_pkg::CEIL_NUM_W;
    localparam int CP = agdm_pkg::CEIL_PROD_W;
    localparam int GP = SB + agdm_pkg::GAMMA_BITS;

    agdm_pkg::t_state r_state;
    agdm_pkg::t_state n_state;

    // configuration
    logic                             r_invert;
    logic [agdm_pkg::WEIGHT_BITS-1:0] r_ema_weight;
    logic [SB-1:0]                    r_min_span;
    logic [DW-1:0]                    r_ceiling_floor;

    // per-transaction datapath
    logic [SB-1:0] r_light;
    logic [SB-1:0] r_knob;
    logic [SB-1:0] r_knob_low;
    logic [SB-1:0] r_knob_high;
    logic [SB-1:0] r_span;
    logic [SB-1:0] r_diff;
    logic [SB-1:0] r_num;
    logic [UW-1:0] r_rem;
    logic [QB-1:0] r_acc;
    logic [RW-1:0] r_root;
    logic [DW-1:0] r_gamma;
    logic [CW-1:0] r_cnt;
    logic [CM-1:0] r_cnum;
    logic [DW-1:0] r_ceil;

    logic          r_out_valid;
    logic [DW-1:0] r_duty;
    logic [SB-1:0] r_level;
    logic [SB-1:0] r_low;
    logic [SB-1:0] r_high;

    logic [UW-1:0] w_a;
    logic [UW-1:0] w_b;
    logic [UW-1:0] w_diff;
    logic          w_ge;
    logic          w_in_xfer;
    logic          w_slot_free;

    logic [SB-1:0] w_ms;
    logic [SB-1:0] w_range;
    logic [SB-1:0] w_diff_clip;
    logic [GP-1:0] w_gprod;
    logic [CM-1:0] w_cnum;
    logic [CP-1:0] w_cprod;
    logic [RW:0]   w_root_inc;
    logic [DW:0]   w_ceiling;
    logic [DW-1:0] w_duty;

    agdm_pkg::t_avg_cmd    w_avg_cmd;
    agdm_pkg::t_light_stat w_stat;

    agdm_sub_unit u_sub (
        .i_a    (w_a),
        .i_b    (w_b),
        .o_diff (w_diff),
        .o_ge   (w_ge)
    );

    agdm_light_avg u_light (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_avg_cmd),
        .i_weight (r_ema_weight),
        .o_stat   (w_stat)
    );

    assign o_cfg_ready = 1'b1;
    assign w_in_xfer   = i_in_valid & o_in_ready;
    assign w_slot_free = ~r_out_valid | i_out_ready;

    assign w_avg_cmd.start  = (r_state == agdm_pkg::S_RANGE);
    assign w_avg_cmd.sample = r_light;

    assign w_ms        = (r_min_span == '0) ? SB'(1) : r_min_span;
    assign w_range     = r_knob_high - r_knob_low;
    assign w_diff_clip = (r_diff > r_span) ? r_span : r_diff;
    assign w_gprod     = GP'(agdm_pkg::GAMMA_SCALE) * GP'(r_num);
    assign w_cnum      = CM'(r_knob) * CM'(agdm_pkg::CEIL_MUL) + CM'(agdm_pkg::SMAX);
    assign w_cprod     = CP'(r_cnum) * CP'(agdm_pkg::CEIL_RECIP);
    // largest k with 2k-1 <= isqrt
    assign w_root_inc  = {1'b0, r_root} + (RW + 1)'(1);
    assign w_ceiling   = {1'b0, r_ceiling_floor} + {1'b0, r_ceil};
    assign w_duty      = ({1'b0, r_gamma} > w_ceiling) ? w_ceiling[DW-1:0] : r_gamma;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            agdm_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = agdm_pkg::S_RANGE;
                end
            end
            agdm_pkg::S_RANGE:     n_state = agdm_pkg::S_NORM;
            agdm_pkg::S_NORM:      n_state = agdm_pkg::S_NUM;
            agdm_pkg::S_NUM:       n_state = agdm_pkg::S_SCALE;
            agdm_pkg::S_SCALE:     n_state = agdm_pkg::S_DIV;
            agdm_pkg::S_DIV: begin
                if (r_cnt == '0) begin
                    n_state = agdm_pkg::S_ROOT;
                end
            end
            agdm_pkg::S_ROOT: begin
                if (r_cnt == '0) begin
                    n_state = agdm_pkg::S_CEIL;
                end
            end
            agdm_pkg::S_CEIL:      n_state = agdm_pkg::S_FIN;
            agdm_pkg::S_FIN: begin
                if (w_slot_free) begin
                    n_state = agdm_pkg::S_IDLE;
                end
            end
            default: n_state = agdm_pkg::S_IDLE;
        endcase
    end

    // outputs: ready and operands of the shared unit
    always_comb begin
        o_in_ready = 1'b0;
        w_a        = '0;
        w_b        = '0;
        unique case (r_state)
            agdm_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
            end
            agdm_pkg::S_DIV: begin
                w_a = {r_rem[UW-2:0], r_acc[QB-1]};
                w_b = UW'(r_span);
            end
            agdm_pkg::S_ROOT: begin
                w_a = {r_rem[UW-3:0], r_acc[QB-1:QB-2]};
                w_b = UW'({r_root, 2'b01});
            end
            default: begin
                w_a = '0;
                w_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= agdm_pkg::S_IDLE;
            r_invert        <= 1'b1;
            r_ema_weight    <= agdm_pkg::WEIGHT_BITS'(983);
            r_min_span      <= SB'(20);
            r_ceiling_floor <= DW'(20);
            r_knob_low      <= agdm_pkg::SMAX;
            r_knob_high     <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    agdm_pkg::CFG_INVERT:        r_invert        <= i_cfg_data[0];
                    agdm_pkg::CFG_EMA_WEIGHT:    r_ema_weight    <= i_cfg_data;
                    agdm_pkg::CFG_MIN_SPAN:      r_min_span      <= i_cfg_data[SB-1:0];
                    agdm_pkg::CFG_CEILING_FLOOR: r_ceiling_floor <= i_cfg_data[DW-1:0];
                    default: ;
                endcase
            end
            if (r_state == agdm_pkg::S_RANGE) begin
                if (r_knob < r_knob_low) begin
                    r_knob_low <= r_knob;
                end
                if (r_knob > r_knob_high) begin
                    r_knob_high <= r_knob;
                end
            end
            if (r_state == agdm_pkg::S_FIN && w_slot_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_light <= i_light_sample;
            r_knob  <= i_knob_sample;
        end
        unique case (r_state)
            agdm_pkg::S_NORM: begin
                r_span <= (w_range < w_ms) ? w_ms : w_range;
                r_diff <= r_knob - r_knob_low;
            end
            agdm_pkg::S_NUM: begin
                r_num <= r_invert ? (r_span - w_diff_clip) : w_diff_clip;
            end
            agdm_pkg::S_SCALE: begin
                // quotient fits QB bits, so the upper part is already below the span
                r_rem  <= UW'(w_gprod[GP-1:QB]);
                r_acc  <= w_gprod[QB-1:0];
                r_cnt  <= CW'(QB - 1);
                r_cnum <= w_cnum;
            end
            agdm_pkg::S_DIV: begin
                r_acc <= {r_acc[QB-2:0], w_ge};
                if (r_cnt == '0) begin
                    r_rem  <= '0;
                    r_root <= '0;
                    r_cnt  <= CW'(RW - 1);
                end else begin
                    r_rem <= w_ge ? w_diff : w_a;
                    r_cnt <= r_cnt - CW'(1);
                end
            end
            agdm_pkg::S_ROOT: begin
                r_acc  <= {r_acc[QB-3:0], 2'b00};
                r_rem  <= w_ge ? w_diff : w_a;
                r_root <= {r_root[RW-2:0], w_ge};
                r_cnt  <= r_cnt - CW'(1);
            end
            agdm_pkg::S_CEIL: begin
                r_gamma <= DW'(w_root_inc[RW:1]);
                r_ceil  <= w_cprod[agdm_pkg::CEIL_SHIFT +: DW];
            end
            agdm_pkg::S_FIN: begin
                if (w_slot_free) begin
                    r_duty  <= w_duty;
                    r_level <= w_stat.level;
                    r_low   <= w_stat.low;
                    r_high  <= w_stat.high;
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid   = r_out_valid;
    assign o_duty        = r_duty;
    assign o_light_level = r_level;
    assign o_light_low   = r_low;
    assign o_light_high  = r_high;

endmodule

FILE: verif/agdm_duty_checker.sv
`timescale 1ns / 1ps
module agdm_duty_checker
    import agdm_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  logic                   i_in_ready,
    input  logic [SAMPLE_BITS-1:0] i_light_sample,
    input  logic [SAMPLE_BITS-1:0] i_knob_sample,
    input  logic                   i_out_valid,
    input  logic                   i_out_ready,
    input  logic [DUTY_W-1:0]      i_duty,
    input  logic [SAMPLE_BITS-1:0] i_light_level,
    input  logic [SAMPLE_BITS-1:0] i_light_low,
    input  logic [SAMPLE_BITS-1:0] i_light_high,
    input  logic                   i_cfg_valid,
    input  logic                   i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    output int                     o_errors,
    output int                     o_pending
);

    typedef struct packed {
        logic [DUTY_W-1:0]      duty;
        logic [SAMPLE_BITS-1:0] level;
        logic [SAMPLE_BITS-1:0] low;
        logic [SAMPLE_BITS-1:0] high;
    } t_duty_result;

    // register copies
    logic                   invert_q;
    logic [WEIGHT_BITS-1:0] weight_q;
    logic [SAMPLE_BITS-1:0] min_span_q;
    logic [DUTY_W-1:0]      ceil_floor_q;

    // tracked state
    logic [SAMPLE_BITS-1:0] knob_lo;
    logic [SAMPLE_BITS-1:0] knob_hi;
    longint unsigned        light_ema;
    logic                   ema_seeded;
    logic [SAMPLE_BITS-1:0] level_lo;
    logic [SAMPLE_BITS-1:0] level_hi;

    t_duty_result duty_results_q[$];
    int           mismatches = 0;
    int           waiting = 0;

    assign o_errors  = mismatches;
    assign o_pending = waiting;

    // largest k with 255*sqrt(n/d) >= k - 1/2, so ties round up
    function automatic logic [DUTY_W-1:0] sqrt_gamma(longint unsigned n, longint unsigned d);
        logic [DUTY_W-1:0] best;
        longint unsigned   odd;
        best = '0;
        for (int k = 1; k <= 255; k++) begin
            odd = longint'(2 * k - 1);
            if (longint'(GAMMA_SCALE) * n >= odd * odd * d)
                best = DUTY_W'(k);
        end
        return best;
    endfunction

    function automatic t_duty_result map_sample(logic [SAMPLE_BITS-1:0] light,
                                                logic [SAMPLE_BITS-1:0] knob);
        t_duty_result    res;
        longint unsigned w, scaled, span, diff, num, ms, ceiling, duty;
        logic [SAMPLE_BITS-1:0] level;
        w = longint'(weight_q);
        scaled = longint'(light);
        scaled = scaled << FRAC_BITS;
        if (!ema_seeded) begin
            light_ema  = scaled;
            ema_seeded = 1'b1;
        end
        light_ema = (w * scaled + (65536 - w) * light_ema + 32768) >> FRAC_BITS;
        level = SAMPLE_BITS'(light_ema >> FRAC_BITS);
        if (level < level_lo) level_lo = level;
        if (level > level_hi) level_hi = level;

        if (knob < knob_lo) knob_lo = knob;
        if (knob > knob_hi) knob_hi = knob;
        ms   = (min_span_q == 0) ? 1 : longint'(min_span_q);
        span = longint'(knob_hi) - longint'(knob_lo);
        if (span < ms) span = ms;
        diff = longint'(knob) - longint'(knob_lo);
        if (diff > span) diff = span;
        num  = invert_q ? (span - diff) : diff;
        duty = longint'(sqrt_gamma(num, span));

        ceiling = longint'(ceil_floor_q)
                + (longint'(knob) * 510 + longint'(SMAX)) / (2 * longint'(SMAX));
        if (duty > ceiling) duty = ceiling;
        if (duty > 255) duty = 255;

        res.duty  = DUTY_W'(duty);
        res.level = level;
        res.low   = level_lo;
        res.high  = level_hi;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_duty_result want;
        if (!i_rst_n) begin
            invert_q     = 1'b1;
            weight_q     = WEIGHT_BITS'(983);
            min_span_q   = SAMPLE_BITS'(20);
            ceil_floor_q = DUTY_W'(20);
            knob_lo      = SMAX;
            knob_hi      = '0;
            light_ema    = 0;
            ema_seeded   = 1'b0;
            level_lo     = SMAX;
            level_hi     = '0;
            duty_results_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_INVERT:        invert_q     = i_cfg_data[0];
                    CFG_EMA_WEIGHT:    weight_q     = i_cfg_data[WEIGHT_BITS-1:0];
                    CFG_MIN_SPAN:      min_span_q   = i_cfg_data[SAMPLE_BITS-1:0];
                    CFG_CEILING_FLOOR: ceil_floor_q = i_cfg_data[DUTY_W-1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (duty_results_q.size() == 0) begin
                    $display("%0t: result transaction with nothing expected", $time);
                    mismatches++;
                end else begin
                    want = duty_results_q.pop_front();
                    if (want.duty !== i_duty) begin
                        $display("%0t: duty expected %0d actual %0d", $time, want.duty, i_duty);
                        mismatches++;
                    end
                    if (want.level !== i_light_level) begin
                        $display("%0t: light_level expected %0d actual %0d",
                                 $time, want.level, i_light_level);
                        mismatches++;
                    end
                    if (want.low !== i_light_low) begin
                        $display("%0t: light_low expected %0d actual %0d",
                                 $time, want.low, i_light_low);
                        mismatches++;
                    end
                    if (want.high !== i_light_high) begin
                        $display("%0t: light_high expected %0d actual %0d",
                                 $time, want.high, i_light_high);
                        mismatches++;
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                duty_results_q.push_back(map_sample(i_light_sample, i_knob_sample));
        end
        waiting = duty_results_q.size();
    end

endmodule

FILE: verif/autorange_gamma_duty_mapper_unit_tb.sv
`timescale 1ns / 1ps
module autorange_gamma_duty_mapper_unit_tb;
    import agdm_pkg::*;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_ready;
    logic [SAMPLE_BITS-1:0] i_light_sample = '0;
    logic [SAMPLE_BITS-1:0] i_knob_sample = '0;
    logic                   o_out_valid;
    logic                   i_out_ready = 1'b0;
    logic [DUTY_W-1:0]      o_duty;
    logic [SAMPLE_BITS-1:0] o_light_level;
    logic [SAMPLE_BITS-1:0] o_light_low;
    logic [SAMPLE_BITS-1:0] o_light_high;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;

    int   errors;
    int   pending;
    logic calm = 1'b0;

    always #5 i_clk = ~i_clk;

    autorange_gamma_duty_mapper_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_light_sample (i_light_sample),
        .i_knob_sample  (i_knob_sample),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_duty         (o_duty),
        .o_light_level  (o_light_level),
        .o_light_low    (o_light_low),
        .o_light_high   (o_light_high),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    agdm_duty_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_light_sample (i_light_sample),
        .i_knob_sample  (i_knob_sample),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_duty         (o_duty),
        .i_light_level  (o_light_level),
        .i_light_low    (o_light_low),
        .i_light_high   (o_light_high),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_errors       (errors),
        .o_pending      (pending)
    );

    // result side backpressure
    always @(posedge i_clk)
        i_out_ready <= calm || ($urandom_range(0, 99) >= 14);

    // valid stays high between back-to-back transactions
    task automatic push_sample(input logic [SAMPLE_BITS-1:0] light,
                               input logic [SAMPLE_BITS-1:0] knob);
        int gap;
        gap = 0;
        if (!calm && $urandom_range(0, 99) < 14)
            gap = $urandom_range(1, 60);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_light_sample <= light;
        i_knob_sample  <= knob;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic set_regs(input logic [CFG_DATA_W-1:0] inv,
                            input logic [CFG_DATA_W-1:0] weight,
                            input logic [CFG_DATA_W-1:0] span,
                            input logic [CFG_DATA_W-1:0] ceil_floor);
        write_reg(CFG_INVERT, inv);
        write_reg(CFG_EMA_WEIGHT, weight);
        write_reg(CFG_MIN_SPAN, span);
        write_reg(CFG_CEILING_FLOOR, ceil_floor);
        i_cfg_valid <= 1'b0;
    endtask

    // wait for every expected result so the block is idle
    task automatic settle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    function automatic logic [SAMPLE_BITS-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return SMAX;
            2:       return SAMPLE_BITS'($urandom_range(0, 15));
            3:       return SAMPLE_BITS'($urandom_range(4080, 4095));
            default: return SAMPLE_BITS'($urandom_range(0, 4095));
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_reg(input logic [CFG_DATA_W-1:0] lo,
                                                        input logic [CFG_DATA_W-1:0] hi);
        case ($urandom_range(0, 4))
            0:       return lo;
            1:       return hi;
            2:       return CFG_DATA_W'($urandom_range(lo, hi));
            default: return CFG_DATA_W'($urandom);
        endcase
    endfunction

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // narrow knob range first, at first below the default min span, seeds the average
        push_sample(12'd2000, 12'd2000);
        push_sample(12'd2000, 12'd2005);
        push_sample(12'd2010, 12'd2010);
        push_sample(12'd4095, 12'd2030);
        push_sample(12'd0, 12'd2025);
        settle();

        // no inversion, full weight, zero min span acts as one, no floor
        set_regs(16'd0, 16'hFFFF, 16'd0, 16'd0);
        push_sample(12'd1000, 12'd2030);
        push_sample(12'd3000, 12'd2000);
        push_sample(12'd3000, 12'd2015);
        settle();

        // upper bits of the invert, min span and floor writes are dropped; weight zero freezes the average
        set_regs(16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF);
        push_sample(12'd4095, 12'd0);
        push_sample(12'd0, 12'd4095);
        push_sample(12'd2048, 12'd2048);
        push_sample(12'd123, 12'd4095);
        push_sample(12'd4095, 12'd1);
        settle();

        // min span of one through a wide write, cap above range
        set_regs(16'hFFFE, 16'hFFFF, 16'hF001, 16'h00FF);
        push_sample(12'd0, 12'd0);
        push_sample(12'd4095, 12'd4095);
        push_sample(12'd2047, 12'd2048);
        push_sample(12'd1, 12'd4094);
        settle();

        set_regs(16'd1, 16'd32768, 16'd1, 16'd0);
        push_sample(12'd4095, 12'd0);
        push_sample(12'd0, 12'd4095);
        push_sample(12'd3000, 12'd1234);
        settle();

        for (int phase = 0; phase < 10; phase++) begin
            calm = (phase == 4);
            if (phase == 0)
                set_regs(16'd0, 16'd0, 16'd1, 16'd0);
            else if (phase == 1)
                set_regs(16'd1, 16'hFFFF, 16'd4095, 16'd255);
            else
                set_regs(CFG_DATA_W'($urandom), pick_reg(16'd0, 16'hFFFF),
                         pick_reg(16'd1, 16'd4095), pick_reg(16'd0, 16'd255));
            repeat (40) push_sample(pick_sample(), pick_sample());
            settle();
        end
        calm = 1'b0;

        // catch any result beyond the expected ones
        repeat (100) @(posedge i_clk);
        if (pending != 0)
            $display("%0t: %0d expected results never arrived", $time, pending);
        if (errors == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
